// File: src/binary_command_frame_parser_unit_macros.svh
// assertion macros shared by the frame parser modules
`ifndef BINARY_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH
`define BINARY_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH

// property checked every clock outside reset
`define BCFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence checked in the clock after the antecedent
`define BCFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/bcfp_pkg.sv
// types and constants of the binary command frame parser
package bcfp_pkg;

    localparam logic [7:0] START_BYTE = 8'h80;

    localparam int CMD_DEPTH = 2;

    localparam logic [2:0] CFG_CHECKSUM_ENABLE = 3'd0;
    localparam logic [2:0] CFG_CHECKSUM_BYTES  = 3'd1;
    localparam logic [2:0] CFG_MAX_PAYLOAD     = 3'd2;
    localparam logic [2:0] CFG_COMMAND_OPCODES = 3'd3;
    localparam logic [2:0] CFG_COMMAND_COUNT   = 3'd4;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [1:0] ST_FOUND       = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd1;
    localparam logic [1:0] ST_WRONG_START = 2'd2;
    localparam logic [1:0] ST_TOO_LONG    = 2'd3;

    localparam logic [1:0] OP_PAYLOAD          = 2'd0;
    localparam logic [1:0] OP_COMPLETE         = 2'd1;
    localparam logic [1:0] OP_ERROR            = 2'd2;
    localparam logic [1:0] OP_PAYLOAD_COMPLETE = 2'd3;

    typedef struct packed {
        logic        checksum_enable;
        logic [2:0]  checksum_bytes;
        logic [15:0] max_payload;
        logic [63:0] command_opcodes;
        logic [3:0]  command_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic [15:0] index;
        logic [1:0]  status;
        logic [31:0] frame_id;
        logic [7:0]  opcode;
        logic [7:0]  encrypt;
        logic [15:0] length;
        logic [31:0] checksum;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [1:0]  status;
        logic [31:0] frame_id;
        logic [7:0]  opcode_out;
        logic [7:0]  encrypt_flag;
        logic [15:0] payload_length;
        logic [31:0] checksum_value;
        logic [2:0]  command_slot;
        logic        last;
    } t_res;

endpackage

// File: src/bcfp_front.sv
// frame parser front: byte state machine and header capture
module bcfp_front import bcfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  t_cfg       i_cfg,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ID   = 3'd1;
    localparam logic [2:0] PH_OPC  = 3'd2;
    localparam logic [2:0] PH_ENC  = 3'd3;
    localparam logic [2:0] PH_LEN  = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;
    localparam logic [2:0] PH_CSUM = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_cnt, n_cnt;
    logic [31:0] r_id, n_id;
    logic [7:0]  r_opc, n_opc;
    logic [7:0]  r_enc, n_enc;
    logic [15:0] r_len, n_len;
    logic [31:0] r_csum, n_csum;

    logic [15:0] len_new;
    logic [31:0] csum_new;
    logic [2:0]  csum_count;
    logic        data_end;

    assign len_new  = {r_len[7:0], i_data_byte};
    assign csum_new = {r_csum[23:0], i_data_byte};
    assign data_end = ({1'b0, r_cnt} + 17'd1) >= {1'b0, r_len};

    always_comb begin
        priority if (i_cfg.checksum_bytes == 3'd0) begin
            csum_count = 3'd1;
        end else if (i_cfg.checksum_bytes > 3'd4) begin
            csum_count = 3'd4;
        end else begin
            csum_count = i_cfg.checksum_bytes;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_id    = r_id;
        n_opc   = r_opc;
        n_enc   = r_enc;
        n_len   = r_len;
        n_csum  = r_csum;

        o_cmd_valid    = 1'b0;
        o_cmd.op       = OP_PAYLOAD;
        o_cmd.data     = i_data_byte;
        o_cmd.index    = r_cnt;
        o_cmd.status   = ST_FOUND;
        o_cmd.frame_id = r_id;
        o_cmd.opcode   = r_opc;
        o_cmd.encrypt  = r_enc;
        o_cmd.length   = r_len;
        o_cmd.checksum = 32'd0;

        if (i_valid) begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_cnt  = 16'd0;
                    n_id   = 32'd0;
                    n_opc  = 8'd0;
                    n_enc  = 8'd0;
                    n_len  = 16'd0;
                    n_csum = 32'd0;
                    if (i_data_byte == START_BYTE) begin
                        n_phase = PH_ID;
                        n_cnt   = 16'd4;
                    end else begin
                        o_cmd_valid    = 1'b1;
                        o_cmd.op       = OP_ERROR;
                        o_cmd.status   = ST_WRONG_START;
                        o_cmd.frame_id = 32'd0;
                        o_cmd.opcode   = 8'd0;
                        o_cmd.encrypt  = 8'd0;
                        o_cmd.length   = 16'd0;
                    end
                end
                PH_ID: begin
                    n_id  = {r_id[23:0], i_data_byte};
                    n_cnt = r_cnt - 16'd1;
                    if (r_cnt == 16'd1) begin
                        n_phase = PH_OPC;
                    end
                end
                PH_OPC: begin
                    n_opc   = i_data_byte;
                    n_phase = PH_ENC;
                end
                PH_ENC: begin
                    n_enc   = i_data_byte;
                    n_phase = PH_LEN;
                    n_cnt   = 16'd2;
                end
                PH_LEN: begin
                    n_len        = len_new;
                    n_cnt        = r_cnt - 16'd1;
                    o_cmd.length = len_new;
                    if (r_cnt == 16'd1) begin
                        priority if (len_new > i_cfg.max_payload) begin
                            o_cmd_valid  = 1'b1;
                            o_cmd.op     = OP_ERROR;
                            o_cmd.status = ST_TOO_LONG;
                            n_phase      = PH_IDLE;
                            n_cnt        = 16'd0;
                            n_id         = 32'd0;
                            n_opc        = 8'd0;
                            n_enc        = 8'd0;
                            n_len        = 16'd0;
                            n_csum       = 32'd0;
                        end else if (len_new == 16'd0 && i_cfg.checksum_enable) begin
                            n_csum  = 32'd0;
                            n_cnt   = {13'd0, csum_count};
                            n_phase = PH_CSUM;
                        end else if (len_new == 16'd0) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.op    = OP_COMPLETE;
                            n_phase     = PH_IDLE;
                            n_cnt       = 16'd0;
                            n_id        = 32'd0;
                            n_opc       = 8'd0;
                            n_enc       = 8'd0;
                            n_len       = 16'd0;
                            n_csum      = 32'd0;
                        end else begin
                            n_phase = PH_DATA;
                            n_cnt   = 16'd0;
                        end
                    end
                end
                PH_DATA: begin
                    o_cmd_valid = 1'b1;
                    n_cnt       = r_cnt + 16'd1;
                    if (data_end && i_cfg.checksum_enable) begin
                        n_csum  = 32'd0;
                        n_cnt   = {13'd0, csum_count};
                        n_phase = PH_CSUM;
                    end else if (data_end) begin
                        o_cmd.op = OP_PAYLOAD_COMPLETE;
                        n_phase  = PH_IDLE;
                        n_cnt    = 16'd0;
                        n_id     = 32'd0;
                        n_opc    = 8'd0;
                        n_enc    = 8'd0;
                        n_len    = 16'd0;
                        n_csum   = 32'd0;
                    end
                end
                PH_CSUM: begin
                    n_csum = csum_new;
                    n_cnt  = r_cnt - 16'd1;
                    if (r_cnt == 16'd1) begin
                        o_cmd_valid    = 1'b1;
                        o_cmd.op       = OP_COMPLETE;
                        o_cmd.checksum = i_cfg.checksum_enable ? csum_new : 32'd0;
                        n_phase        = PH_IDLE;
                        n_cnt          = 16'd0;
                        n_id           = 32'd0;
                        n_opc          = 8'd0;
                        n_enc          = 8'd0;
                        n_len          = 16'd0;
                        n_csum         = 32'd0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_cnt   = 16'd0;
                    n_id    = 32'd0;
                    n_opc   = 8'd0;
                    n_enc   = 8'd0;
                    n_len   = 16'd0;
                    n_csum  = 32'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 16'd0;
            r_id    <= 32'd0;
            r_opc   <= 8'd0;
            r_enc   <= 8'd0;
            r_len   <= 16'd0;
            r_csum  <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_id    <= n_id;
            r_opc   <= n_opc;
            r_enc   <= n_enc;
            r_len   <= n_len;
            r_csum  <= n_csum;
        end
    end

endmodule

// File: src/bcfp_fifo.sv
// small register queue between the parser front and back
`include "binary_command_frame_parser_unit_macros.svh"
module bcfp_fifo import bcfp_pkg::*; #(
    parameter type t_item = t_cmd,
    parameter int  DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == CW'(0));
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    `BCFP_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(DEPTH), "queue count over depth")
    `BCFP_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `BCFP_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty), "pop from empty queue")

endmodule

// File: src/bcfp_back.sv
// frame parser back: opcode lookup and expansion into result items
`include "binary_command_frame_parser_unit_macros.svh"
module bcfp_back import bcfp_pkg::*; #(
    parameter int MAX_COMMANDS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_empty,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_res_pop,
    output logic o_res_valid,
    output t_res o_res
);

    logic r_valid, n_valid;
    logic r_second, n_second;
    t_res r_res, n_res;

    logic       load;
    logic       found;
    logic [2:0] slot;

    assign load = !r_valid || i_res_pop;

    always_comb begin
        found = 1'b0;
        slot  = 3'd0;
        for (int i = 0; i < MAX_COMMANDS; i++) begin
            if (!found && (i_cfg.command_count > 4'(i))
                    && (i_cfg.command_opcodes[8*i +: 8] == i_cmd.opcode)) begin
                found = 1'b1;
                slot  = 3'(i);
            end
        end
    end

    always_comb begin
        n_valid   = r_valid && !i_res_pop;
        n_second  = r_second;
        n_res     = r_res;
        o_cmd_pop = 1'b0;

        if (load && !i_cmd_empty) begin
            n_valid              = 1'b1;
            n_res.kind           = KIND_PAYLOAD;
            n_res.payload_byte   = i_cmd.data;
            n_res.byte_index     = i_cmd.index;
            n_res.status         = ST_FOUND;
            n_res.frame_id       = i_cmd.frame_id;
            n_res.opcode_out     = i_cmd.opcode;
            n_res.encrypt_flag   = i_cmd.encrypt;
            n_res.payload_length = i_cmd.length;
            n_res.checksum_value = 32'd0;
            n_res.command_slot   = 3'd0;
            n_res.last           = 1'b1;
            o_cmd_pop            = 1'b1;

            if (r_second || i_cmd.op == OP_COMPLETE) begin
                n_res.kind           = KIND_COMPLETE;
                n_res.payload_byte   = 8'd0;
                n_res.byte_index     = 16'd0;
                n_res.status         = found ? ST_FOUND : ST_NOT_FOUND;
                n_res.checksum_value = i_cmd.checksum;
                n_res.command_slot   = found ? slot : 3'd0;
                n_second             = 1'b0;
            end else begin
                unique case (i_cmd.op)
                    OP_ERROR: begin
                        n_res.kind         = KIND_ERROR;
                        n_res.payload_byte = 8'd0;
                        n_res.byte_index   = 16'd0;
                        n_res.status       = i_cmd.status;
                    end
                    OP_PAYLOAD_COMPLETE: begin
                        n_res.last = 1'b0;
                        n_second   = 1'b1;
                        o_cmd_pop  = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_res;

    `BCFP_ASSERT(a_second_has_cmd, i_clk, i_rst_n, r_second |-> !i_cmd_empty, "second half lost its item")
    `BCFP_ASSERT(a_second_op, i_clk, i_rst_n, r_second |-> (i_cmd.op == OP_PAYLOAD_COMPLETE), "second half on wrong item")
    `BCFP_ASSERT(a_last_kind, i_clk, i_rst_n, (r_valid && !r_res.last) |-> (r_res.kind == KIND_PAYLOAD), "non-final result not payload")
    `BCFP_ASSERT_NEXT(a_first_then_second, i_clk, i_rst_n, r_valid && !r_res.last, r_second || r_valid, "payload half without follow-up")

endmodule

// File: src/binary_command_frame_parser_unit.sv
// top level of the binary command frame parser
//
// channel   direction  handshake            payload
// input     in         i_push / o_full      i_data_byte
// result    out        o_empty / i_pop      o_kind .. o_last
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one byte accepted per cycle unless o_full; results pass the queue and a register
// a final payload byte with no checksum gives a payload item, then a complete item
// o_full rises when the two-entry command queue fills behind an unpopped result
// synchronous reset loads the register defaults
// config writes complete every cycle; o_cfg_ready is always high
module binary_command_frame_parser_unit import bcfp_pkg::*; #(
    parameter int MAX_COMMANDS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_byte_index,
    output logic [1:0]  o_status,
    output logic [31:0] o_frame_id,
    output logic [7:0]  o_opcode_out,
    output logic [7:0]  o_encrypt_flag,
    output logic [15:0] o_payload_length,
    output logic [31:0] o_checksum_value,
    output logic [2:0]  o_command_slot,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg r_cfg;
    logic accept;
    logic cmd_valid, cmd_full, cmd_empty, cmd_pop;
    t_cmd cmd_in, cmd_head;
    logic res_valid;
    t_res res;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !cmd_full;
    assign o_full      = cmd_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.checksum_enable <= 1'b0;
            r_cfg.checksum_bytes  <= 3'd2;
            r_cfg.max_payload     <= 16'd1024;
            r_cfg.command_opcodes <= 64'd0;
            r_cfg.command_count   <= 4'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHECKSUM_ENABLE: r_cfg.checksum_enable <= i_cfg_data[0];
                CFG_CHECKSUM_BYTES:  r_cfg.checksum_bytes  <= i_cfg_data[2:0];
                CFG_MAX_PAYLOAD:     r_cfg.max_payload     <= i_cfg_data[15:0];
                CFG_COMMAND_OPCODES: r_cfg.command_opcodes <= i_cfg_data;
                CFG_COMMAND_COUNT:   r_cfg.command_count   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    bcfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_data_byte (i_data_byte),
        .i_cfg       (r_cfg),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    bcfp_fifo #(
        .t_item (t_cmd),
        .DEPTH  (CMD_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_head)
    );

    bcfp_back #(
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_res_pop   (i_pop),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_empty          = !res_valid;
    assign o_kind           = res.kind;
    assign o_payload_byte   = res.payload_byte;
    assign o_byte_index     = res.byte_index;
    assign o_status         = res.status;
    assign o_frame_id       = res.frame_id;
    assign o_opcode_out     = res.opcode_out;
    assign o_encrypt_flag   = res.encrypt_flag;
    assign o_payload_length = res.payload_length;
    assign o_checksum_value = res.checksum_value;
    assign o_command_slot   = res.command_slot;
    assign o_last           = res.last;

endmodule
